// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check: prop must hold at every clock edge outside reset
`define CHECK_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`endif

// File: rtl/p2dq_pkg.sv
// Package for pow2_dequantize_to_float: payload structs, constants, register indexes.
// No dependencies.
`default_nettype none
package p2dq_pkg;
   localparam int MaxChannels = 256;
   localparam int ChanBits    = $clog2(MaxChannels);

   localparam logic       CmdTableWrite = 1'b0;
   localparam logic       CmdSample     = 1'b1;
   localparam logic [1:0] RegChannelCount = 2'd0;
   localparam logic [1:0] RegElements     = 2'd1;
   localparam logic [1:0] RegSampleByte   = 2'd2;

   typedef struct packed {
      logic              command;
      logic [7:0]        channel_index;
      logic signed [7:0] fraction_length;
      logic signed [15:0] sample;
   } req_type;

   typedef struct packed {
      logic [31:0] float_bits;
      logic        last;
   } rsp_type;

   // Side information that travels with a sample down the pipe
   typedef struct packed {
      logic              sign;
      logic [15:0]       mag;
      logic              last;
   } smp_type;
endpackage
`default_nettype wire

// File: rtl/p2dq_table.sv
// Fraction-length table: 256 x 8 synchronous memory, one write and one read port.
// Depends on p2dq_pkg.
`default_nettype none
module p2dq_table (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [p2dq_pkg::ChanBits-1:0] wr_addr,
   input  wire logic [7:0]                wr_data,
   input  wire logic                      rd_en,
   input  wire logic [p2dq_pkg::ChanBits-1:0] rd_addr,
   output logic [7:0]                     rd_data
);
   import p2dq_pkg::*;
   logic [7:0] mem [MaxChannels];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: rtl/p2dq_convert.sv
// Integer magnitude and power-of-two scale to IEEE single bits, combinational.
// Depends on p2dq_pkg.
`default_nettype none
module p2dq_convert (
   input  wire logic                  sign,
   input  wire logic [15:0]           mag,
   input  wire logic signed [7:0]     frac,
   output logic [31:0]                float_bits
);
   import p2dq_pkg::*;
   logic [3:0]        top;
   logic signed [9:0] expo;
   logic [15:0]       norm;

   always_comb begin
      top = 4'd0;
      for (int i = 1; i < 16; i++) begin
         if (mag[i]) top = 4'(i);
      end
      expo = $signed({6'd0, top}) - 10'(frac);
      norm = mag << (4'd15 - top);
      if (mag == 16'd0) float_bits = 32'd0;
      else if (expo > 10'sd127) float_bits = {sign, 8'hFF, 23'd0};
      else if (expo < -10'sd126) float_bits = {sign, 31'd0};
      else begin
         float_bits = {sign, 8'(expo + 10'sd127), norm[14:0], 8'd0};
      end
   end
endmodule
`default_nettype wire

// File: rtl/pow2_dequantize_to_float.sv
// A sample request goes through the table read, then conversion into the output register.
// Throughput: one request per cycle unless the output stalls; writes give no result.
// The rate is set by the single read port of the fraction-length table, used once per sample.
// Reset: sync, active high; counts to 1; clears byte mode, positions, valids; table undefined.
`include "assert_macros.svh"
`default_nettype none
module pow2_dequantize_to_float (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire p2dq_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output p2dq_pkg::rsp_type       rsp_data,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_data
);
   import p2dq_pkg::*;

   logic [8:0]  chan_cnt_ff;
   logic [15:0] elems_ff;
   logic        byte_ff;
   logic [ChanBits-1:0] chan_pos_ff, chan_pos_in;
   logic [15:0] elem_pos_ff, elem_pos_in;

   // stage 1: table read in flight
   logic        s1_valid_ff;
   smp_type     s1_ff;
   // output register
   logic        out_valid_ff;
   rsp_type     out_ff;

   logic        advance, acc, acc_smp, acc_wr, last_in;
   logic [15:0] val16;
   smp_type     s1_in;
   logic [7:0]  tbl_rd;
   logic signed [7:0] frac;
   logic [31:0] fbits;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign acc       = req_valid && !req_stall;
   assign acc_smp   = acc && (req_data.command == CmdSample);
   assign acc_wr    = acc && (req_data.command == CmdTableWrite);
   assign csr_ready = 1'b1;

   always_comb begin
      elem_pos_in = elem_pos_ff + 16'd1;
      chan_pos_in = chan_pos_ff;
      last_in     = 1'b0;
      if (17'(elem_pos_ff) + 17'd1 >= 17'(elems_ff)) begin
         elem_pos_in = 16'd0;
         if (10'(chan_pos_ff) + 10'd1 >= 10'(chan_cnt_ff)) begin
            last_in     = 1'b1;
            chan_pos_in = '0;
         end else begin
            chan_pos_in = chan_pos_ff + 1'b1;
         end
      end
      val16 = byte_ff ? {{8{req_data.sample[7]}}, req_data.sample[7:0]} : req_data.sample;
      s1_in.sign = val16[15];
      s1_in.mag  = val16[15] ? 16'(-val16) : val16;
      s1_in.last = last_in;
   end

   // at most one request per cycle, so a table write always lands before a later sample reads it
   p2dq_table u_table (
      .clock   (clock),
      .wr_en   (acc_wr),
      .wr_addr (req_data.channel_index[ChanBits-1:0]),
      .wr_data (req_data.fraction_length),
      .rd_en   (acc_smp),
      .rd_addr (chan_pos_ff),
      .rd_data (tbl_rd)
   );

   assign frac = tbl_rd;

   p2dq_convert u_convert (
      .sign       (s1_ff.sign),
      .mag        (s1_ff.mag),
      .frac       (frac),
      .float_bits (fbits)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_cnt_ff  <= 9'd1;
         elems_ff     <= 16'd1;
         byte_ff      <= 1'b0;
         chan_pos_ff  <= '0;
         elem_pos_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               RegChannelCount: chan_cnt_ff <= csr_data[8:0];
               RegElements:     elems_ff    <= csr_data[15:0];
               RegSampleByte:   byte_ff     <= csr_data[0];
               default: ;
            endcase
         end
         if (acc_smp) begin
            chan_pos_ff <= chan_pos_in;
            elem_pos_ff <= elem_pos_in;
         end
         if (advance) begin
            s1_valid_ff  <= acc_smp;
            out_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff       <= s1_in;
         out_ff.float_bits <= fbits;
         out_ff.last       <= s1_ff.last;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `CHECK_CLK(a_stall_holds, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid, "result dropped")
   `CHECK_CLK(a_rsp_stable, clock, reset, (rsp_valid && rsp_stall) |=> $stable(rsp_data), "result changed")
   `CHECK_CLK(a_elem_hold, clock, reset, !acc_smp |=> $stable(elem_pos_ff), "element counter moved")
endmodule
`default_nettype wire
